### src/ucw_pkg.sv
// Shared types and constants for the UTF-8 decoder with terminal column width.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ucw_pkg;

    localparam int BYTE_BITS          = 8;
    localparam int LEN_BITS           = 3;
    localparam int CP_BITS            = 21;
    localparam int COL_BITS           = 2;
    localparam int RUN_BITS           = 16;
    localparam int TOTAL_WIDTH_BITS_DEF = 16;

    // Character lengths in bytes
    localparam logic [LEN_BITS-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_BITS-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_BITS-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_BITS-1:0] LEN_FOUR  = 3'd4;

    // Terminal column widths
    localparam logic [COL_BITS-1:0] COL_ZERO   = 2'd0;
    localparam logic [COL_BITS-1:0] COL_SINGLE = 2'd1;
    localparam logic [COL_BITS-1:0] COL_DOUBLE = 2'd2;

    // Lead and continuation byte patterns
    localparam logic [BYTE_BITS-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_BITS-1:0] PAT_LEAD2  = 8'hC0;
    localparam logic [BYTE_BITS-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_BITS-1:0] PAT_LEAD3  = 8'hE0;
    localparam logic [BYTE_BITS-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_BITS-1:0] PAT_LEAD4  = 8'hF0;
    localparam logic [BYTE_BITS-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_BITS-1:0] PAT_CONT   = 8'h80;

    // Code points and ranges
    localparam logic [CP_BITS-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_BITS-1:0] CP_ASCII_END   = 21'h000080;
    localparam logic [CP_BITS-1:0] CP_C0_END      = 21'h000020;
    localparam logic [CP_BITS-1:0] CP_DEL         = 21'h00007F;
    localparam logic [CP_BITS-1:0] CP_C1_END      = 21'h0000A0;
    localparam logic [CP_BITS-1:0] CP_ZWJ         = 21'h00200D;
    localparam logic [CP_BITS-1:0] CP_VS_LO       = 21'h00FE00;
    localparam logic [CP_BITS-1:0] CP_VS_HI       = 21'h00FE0F;
    localparam logic [CP_BITS-1:0] CP_EMOJI_LO    = 21'h01F300;
    localparam logic [CP_BITS-1:0] CP_EMOJI_HI    = 21'h01FAFF;
    localparam logic [CP_BITS-1:0] CP_SYMB_LO     = 21'h002600;
    localparam logic [CP_BITS-1:0] CP_SYMB_HI     = 21'h0027BF;
    localparam logic [CP_BITS-1:0] CP_TECH_LO     = 21'h002300;
    localparam logic [CP_BITS-1:0] CP_TECH_HI     = 21'h0023FF;

    // One request as held in the input register
    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_first;
        logic [BYTE_BITS-1:0] byte_second;
        logic [BYTE_BITS-1:0] byte_third;
        logic [BYTE_BITS-1:0] byte_fourth;
        logic [LEN_BITS-1:0]  bytes_remaining;
        logic                 start_of_text;
    } req_t;

    // Decoder result
    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic [CP_BITS-1:0]  cp;
    } dec_t;

endpackage
`default_nettype wire

### src/ucw_decode.sv
// UTF-8 decoder: one character from a four-byte window.
// Depends on ucw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ucw_decode (
    input  ucw_pkg::req_t req,
    output ucw_pkg::dec_t dec
);
    import ucw_pkg::*;

    logic [LEN_BITS-1:0] lead_len;
    logic [LEN_BITS-1:0] len;
    logic                cont1;
    logic                cont2;
    logic                cont3;

    assign cont1 = (req.byte_second & MASK_CONT) == PAT_CONT;
    assign cont2 = (req.byte_third  & MASK_CONT) == PAT_CONT;
    assign cont3 = (req.byte_fourth & MASK_CONT) == PAT_CONT;

    always_comb
    begin
        if ((req.byte_first & MASK_LEAD2) == PAT_LEAD2)
            lead_len = LEN_TWO;
        else if ((req.byte_first & MASK_LEAD3) == PAT_LEAD3)
            lead_len = LEN_THREE;
        else if ((req.byte_first & MASK_LEAD4) == PAT_LEAD4)
            lead_len = LEN_FOUR;
        else
            lead_len = LEN_ONE;
    end

    // Fall back to one byte on truncation or a bad continuation
    always_comb
    begin
        len = lead_len;
        if (lead_len != LEN_ONE)
        begin
            if (lead_len > req.bytes_remaining)
                len = LEN_ONE;
            else if (!cont1)
                len = LEN_ONE;
            else if (lead_len >= LEN_THREE && !cont2)
                len = LEN_ONE;
            else if (lead_len == LEN_FOUR && !cont3)
                len = LEN_ONE;
        end
    end

    always_comb
    begin
        dec.len = len;
        case (len)
            LEN_TWO:
                dec.cp = {10'd0, req.byte_first[4:0], req.byte_second[5:0]};
            LEN_THREE:
                dec.cp = {5'd0, req.byte_first[3:0], req.byte_second[5:0],
                          req.byte_third[5:0]};
            LEN_FOUR:
                dec.cp = {req.byte_first[2:0], req.byte_second[5:0],
                          req.byte_third[5:0], req.byte_fourth[5:0]};
            default:
                dec.cp = req.byte_first[7] ? CP_REPLACEMENT
                                           : {13'd0, req.byte_first};
        endcase
    end

endmodule
`default_nettype wire

### src/ucw_width.sv
// Terminal column width of one code point.
// Depends on ucw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ucw_width (
    input  logic [ucw_pkg::CP_BITS-1:0]  cp,
    output logic [ucw_pkg::COL_BITS-1:0] cols
);
    import ucw_pkg::*;

    always_comb
    begin
        if (cp == '0)
            cols = COL_ZERO;
        else if (cp == CP_ZWJ || (cp >= CP_VS_LO && cp <= CP_VS_HI))
            cols = COL_ZERO;
        else if (cp < CP_C0_END || (cp >= CP_DEL && cp < CP_C1_END))
            cols = COL_ZERO;
        else if ((cp >= CP_EMOJI_LO && cp <= CP_EMOJI_HI) ||
                 (cp >= CP_SYMB_LO && cp <= CP_SYMB_HI) ||
                 (cp >= CP_TECH_LO && cp <= CP_TECH_HI))
            cols = COL_DOUBLE;
        else
            cols = COL_SINGLE;
    end

endmodule
`default_nettype wire

### src/utf8_decode_column_width.sv
// Top level of the UTF-8 decoder with terminal column width and running total.
// Depends on ucw_pkg, ucw_decode and ucw_width.
`timescale 1ns / 1ps
`default_nettype none
// Decodes one UTF-8 character per request from a four-byte window at the
// current text position. Each result gives the bytes consumed (advance the
// window by this), the code point, the terminal column width and a running
// column total that restarts when start_of_text is set and saturates at
// 2^TOTAL_WIDTH_BITS - 1; running_width shows its low 16 bits. A bad lead
// byte, a truncated sequence or a bad continuation byte consumes one byte
// and yields U+FFFD, except an ASCII byte, which comes out as itself.
// Overlong forms and surrogates are decoded as they stand. One request is taken
// per cycle while out_ready holds; each passes an input register, then the
// decode, width lookup and saturating add, then the result register. The
// input side keeps taking requests while a result waits, until both
// registers are full; in_ready depends combinationally on out_ready.
module utf8_decode_column_width #(
    parameter int TOTAL_WIDTH_BITS = ucw_pkg::TOTAL_WIDTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ucw_pkg::BYTE_BITS-1:0] byte_first,
    input  logic [ucw_pkg::BYTE_BITS-1:0] byte_second,
    input  logic [ucw_pkg::BYTE_BITS-1:0] byte_third,
    input  logic [ucw_pkg::BYTE_BITS-1:0] byte_fourth,
    input  logic [ucw_pkg::LEN_BITS-1:0]  bytes_remaining,
    input  logic                          start_of_text,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ucw_pkg::LEN_BITS-1:0]  consumed_bytes,
    output logic [ucw_pkg::CP_BITS-1:0]   code_point,
    output logic [ucw_pkg::COL_BITS-1:0]  column_width,
    output logic [ucw_pkg::RUN_BITS-1:0]  running_width
);
    import ucw_pkg::*;

    // Handshake control
    logic in_accept;
    logic s2_ready;
    logic s1_move;

    // Input register
    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_req_reg;

    // Decode path
    dec_t                dec;
    logic [COL_BITS-1:0] cols;

    // Running total
    logic [TOTAL_WIDTH_BITS-1:0]          total_reg;
    logic [TOTAL_WIDTH_BITS-1:0]          total_next;
    logic [TOTAL_WIDTH_BITS-1:0]          total_base;
    logic [TOTAL_WIDTH_BITS:0]            total_sum;
    logic [TOTAL_WIDTH_BITS+RUN_BITS-1:0] total_ext;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LEN_BITS-1:0] len_reg;
    logic [CP_BITS-1:0]  cp_reg;
    logic [COL_BITS-1:0] cols_reg;
    logic [RUN_BITS-1:0] run_reg;

    // Advance the input register whenever the result register frees up
    assign s2_ready  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg.byte_first      <= byte_first;
            s1_req_reg.byte_second     <= byte_second;
            s1_req_reg.byte_third      <= byte_third;
            s1_req_reg.byte_fourth     <= byte_fourth;
            s1_req_reg.bytes_remaining <= bytes_remaining;
            s1_req_reg.start_of_text   <= start_of_text;
        end
    end

    ucw_decode u_decode (
        .req (s1_req_reg),
        .dec (dec)
    );

    ucw_width u_width (
        .cp   (dec.cp),
        .cols (cols)
    );

    // Restart on start_of_text, then add with saturation; the width adds at
    // most two, so the carry out alone flags an overflow.
    assign total_base = s1_req_reg.start_of_text ? '0 : total_reg;
    assign total_sum  = {1'b0, total_base} + (TOTAL_WIDTH_BITS+1)'(cols);
    assign total_next = total_sum[TOTAL_WIDTH_BITS] ? {TOTAL_WIDTH_BITS{1'b1}}
                                                    : total_sum[TOTAL_WIDTH_BITS-1:0];
    assign total_ext  = {{RUN_BITS{1'b0}}, total_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (s1_move)
            total_reg <= total_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            len_reg  <= dec.len;
            cp_reg   <= dec.cp;
            cols_reg <= cols;
            run_reg  <= total_ext[RUN_BITS-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign consumed_bytes = len_reg;
    assign code_point     = cp_reg;
    assign column_width   = cols_reg;
    assign running_width  = run_reg;

`ifndef ASSERT_OFF
    // A one-byte result is either plain ASCII or the replacement character
    a_single_byte_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && consumed_bytes == LEN_ONE |->
            code_point < CP_ASCII_END || code_point == CP_REPLACEMENT)
        else $error("one-byte result with a non-ASCII code point");

    // Consumed count stays within one to four
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> consumed_bytes == LEN_ONE || consumed_bytes == LEN_TWO ||
                      consumed_bytes == LEN_THREE || consumed_bytes == LEN_FOUR)
        else $error("consumed byte count out of range");

    // Without a restart the running total never goes down
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !s1_req_reg.start_of_text |=> total_reg >= $past(total_reg))
        else $error("running total decreased without a restart");

    // The total only changes when a request moves into the result register
    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(total_reg))
        else $error("running total changed with no request advancing");

    // An empty input register always takes a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled while its register is empty");
`endif

endmodule
`default_nettype wire
